### sv/cgl_pkg.sv
// shared types and constants of the color gradient lookup
package cgl_pkg;

  // opcodes of an input beat
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // min_span reset value, about 0.001 in q0.16
  localparam logic [15:0] MIN_SPAN_RST = 16'd66;

  // quotient bits of the fraction divider
  localparam int DIV_STEPS = 16;

  typedef struct packed {
    logic        opcode;
    logic [15:0] position;
    logic [15:0] in_red;
    logic [15:0] in_green;
    logic [15:0] in_blue;
    logic [15:0] in_alpha;
  } in_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
    logic [1:0]  status;
  } out_t;

  // channel 0 red, 1 green, 2 blue, 3 alpha
  typedef logic [3:0][15:0] color_t;

  typedef struct packed {
    logic [15:0] pos;
    color_t      color;
  } stop_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_LK_RD,
    ST_LK_CMP,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

endpackage

### sv/color_gradient_lookup.sv
// Color gradient lookup: sorted stop table with linear color blending.
// Insert: shifts each stop above the new one up one slot, then writes the new stop in place.
// Lookup: scans the stops in order for the first one above the query; when interpolating,
// a serial divider forms the fraction and one multiplier shared by the channels blends them.
// One item at a time; in_ready is high in idle, also while a result waits on out_ready.
// Synchronous reset empties the table, sets min_span to 66 and drops any pending result.
module color_gradient_lookup #(
  parameter int MAX_STOPS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cgl_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output cgl_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata
);

  localparam int IW = $clog2(MAX_STOPS);
  localparam int CW = $clog2(MAX_STOPS + 1);

  cgl_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   idx_inc;
  logic [CW-1:0]   idx_dec;
  logic [15:0]     min_span_r;
  cgl_pkg::in_t    item_r, item_nxt;
  cgl_pkg::stop_t  prev_r, prev_nxt;
  cgl_pkg::stop_t  cur_r, cur_nxt;
  cgl_pkg::color_t res_r, res_nxt;
  logic [1:0]      stat_r, stat_nxt;
  logic [15:0]     frac_r, frac_nxt;
  logic [1:0]      ch_r, ch_nxt;
  logic [33:0]     prod_r, prod_nxt;
  logic            out_valid_r, out_valid_nxt;
  cgl_pkg::out_t   out_data_r, out_data_nxt;

  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  cgl_pkg::stop_t  mem_wdata;
  logic [IW-1:0]   mem_raddr;
  cgl_pkg::stop_t  mem_rdata;
  cgl_pkg::stop_t  new_stop;

  logic            div_start;
  logic            div_done;
  logic [15:0]     div_quo;
  logic [15:0]     span;
  logic [15:0]     offset;
  logic [16:0]     ch_diff;
  logic [17:0]     ch_sum;
  logic            accept;
  logic            out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign idx_inc  = idx_r + CW'(1);
  assign idx_dec  = idx_r - CW'(1);
  assign new_stop = '{pos: item_r.position,
                      color: {item_r.in_alpha, item_r.in_blue, item_r.in_green, item_r.in_red}};
  assign span     = mem_rdata.pos - prev_r.pos;
  assign offset   = item_r.position - prev_r.pos;
  assign ch_diff  = {1'b0, cur_r.color[ch_r]} - {1'b0, prev_r.color[ch_r]};
  assign ch_sum   = {2'b00, prev_r.color[ch_r]} + prod_r[33:16];

  cgl_stop_mem #(
    .DEPTH(MAX_STOPS)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  cgl_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (offset),
    .den  (span),
    .done (div_done),
    .quo  (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cgl_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.opcode == cgl_pkg::OP_INSERT) begin
            state_nxt = (cnt_r >= CW'(MAX_STOPS)) ? cgl_pkg::ST_DONE : cgl_pkg::ST_INS_RD;
          end else begin
            state_nxt = (cnt_r == '0) ? cgl_pkg::ST_DONE : cgl_pkg::ST_LK_RD;
          end
        end
      end
      cgl_pkg::ST_INS_RD: begin
        state_nxt = (idx_r == '0) ? cgl_pkg::ST_DONE : cgl_pkg::ST_INS_CMP;
      end
      cgl_pkg::ST_INS_CMP: begin
        state_nxt = (mem_rdata.pos > item_r.position) ? cgl_pkg::ST_INS_RD : cgl_pkg::ST_DONE;
      end
      cgl_pkg::ST_LK_RD: begin
        state_nxt = cgl_pkg::ST_LK_CMP;
      end
      cgl_pkg::ST_LK_CMP: begin
        if (item_r.position >= mem_rdata.pos) begin
          state_nxt = (idx_inc == cnt_r) ? cgl_pkg::ST_DONE : cgl_pkg::ST_LK_RD;
        end else if (idx_r == '0 || span <= min_span_r) begin
          state_nxt = cgl_pkg::ST_DONE;
        end else begin
          state_nxt = cgl_pkg::ST_DIV;
        end
      end
      cgl_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = cgl_pkg::ST_MUL;
        end
      end
      cgl_pkg::ST_MUL: begin
        state_nxt = cgl_pkg::ST_ACC;
      end
      cgl_pkg::ST_ACC: begin
        state_nxt = (ch_r == 2'd3) ? cgl_pkg::ST_DONE : cgl_pkg::ST_MUL;
      end
      cgl_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = cgl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cgl_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs and datapath updates
  always_comb begin
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    item_nxt      = item_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    res_nxt       = res_r;
    stat_nxt      = stat_r;
    frac_nxt      = frac_r;
    ch_nxt        = ch_r;
    prod_nxt      = prod_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r[IW-1:0];
    mem_wdata     = new_stop;
    mem_raddr     = idx_r[IW-1:0];
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      cgl_pkg::ST_IDLE: begin
        if (accept) begin
          item_nxt = in_data;
          res_nxt  = '0;
          stat_nxt = cgl_pkg::STATUS_OK;
          if (in_data.opcode == cgl_pkg::OP_INSERT) begin
            idx_nxt = cnt_r;
            if (cnt_r >= CW'(MAX_STOPS)) begin
              stat_nxt = cgl_pkg::STATUS_FULL;
            end
          end else begin
            idx_nxt = '0;
            if (cnt_r == '0) begin
              stat_nxt = cgl_pkg::STATUS_EMPTY;
            end
          end
        end
      end
      cgl_pkg::ST_INS_RD: begin
        // slot zero reached: the new stop goes first
        mem_raddr = idx_dec[IW-1:0];
        if (idx_r == '0) begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      cgl_pkg::ST_INS_CMP: begin
        // shift the larger stop up one slot, or place the new one
        mem_we = 1'b1;
        if (mem_rdata.pos > item_r.position) begin
          mem_wdata = mem_rdata;
          idx_nxt   = idx_dec;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      cgl_pkg::ST_LK_CMP: begin
        if (item_r.position >= mem_rdata.pos) begin
          prev_nxt = mem_rdata;
          idx_nxt  = idx_inc;
          if (idx_inc == cnt_r) begin
            res_nxt = mem_rdata.color;
          end
        end else if (idx_r == '0) begin
          res_nxt = mem_rdata.color;
        end else if (span <= min_span_r) begin
          res_nxt = prev_r.color;
        end else begin
          cur_nxt   = mem_rdata;
          div_start = 1'b1;
        end
      end
      cgl_pkg::ST_DIV: begin
        frac_nxt = div_quo;
        ch_nxt   = 2'd0;
      end
      cgl_pkg::ST_MUL: begin
        // signed channel difference times fraction
        prod_nxt = 34'($signed(ch_diff) * $signed({1'b0, frac_r}));
      end
      cgl_pkg::ST_ACC: begin
        res_nxt[ch_r] = ch_sum[15:0];
        ch_nxt        = ch_r + 2'd1;
      end
      cgl_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_red: res_r[0], out_green: res_r[1], out_blue: res_r[2],
                            out_alpha: res_r[3], status: stat_r};
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cgl_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      min_span_r  <= cgl_pkg::MIN_SPAN_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        min_span_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    item_r     <= item_nxt;
    prev_r     <= prev_nxt;
    cur_r      <= cur_nxt;
    res_r      <= res_nxt;
    stat_r     <= stat_nxt;
    frac_r     <= frac_nxt;
    ch_r       <= ch_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == cgl_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/cgl_stop_mem.sv
// stop table memory: one write port, one registered read port
module cgl_stop_mem #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  cgl_pkg::stop_t           wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output cgl_pkg::stop_t           rd_data
);

  cgl_pkg::stop_t mem [DEPTH];
  cgl_pkg::stop_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/cgl_div.sv
// restoring divider for the blend fraction, one quotient bit per cycle
module cgl_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [15:0] quo
);

  localparam int SW = $clog2(cgl_pkg::DIV_STEPS);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic [15:0]   den_r, den_nxt;
  logic [15:0]   quo_r, quo_nxt;
  logic [16:0]   shifted;
  logic [16:0]   diff;

  // one shift, compare and subtract step
  always_comb begin
    shifted  = {rem_r, 1'b0};
    diff     = shifted - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = num;
      den_nxt  = den;
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (!diff[16]) begin
        rem_nxt = diff[15:0];
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = shifted[15:0];
        quo_nxt = {quo_r[14:0], 1'b0};
      end
      step_nxt = step_r + SW'(1);
      if (step_r == SW'(cgl_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### sv/cgl_checker.sv
// port-level checker for the color gradient lookup, with its bind
module cgl_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input cgl_pkg::out_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one item at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == cgl_pkg::STATUS_OK ||
                   out_data.status == cgl_pkg::STATUS_FULL ||
                   out_data.status == cgl_pkg::STATUS_EMPTY))
    else $error("bad status code");

  // error results carry zero color
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != cgl_pkg::STATUS_OK |->
      out_data.out_red == 16'd0 && out_data.out_green == 16'd0 &&
      out_data.out_blue == 16'd0 && out_data.out_alpha == 16'd0)
    else $error("error result with nonzero color");

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind color_gradient_lookup cgl_checker u_cgl_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

### dv/color_gradient_lookup_test.sv
`timescale 1ns / 100ps
// self-checking testbench of the color gradient lookup: directed and random beats
module color_gradient_lookup_test;

  localparam int STOP_DEPTH = 16;
  localparam int IDLE_PCT   = 15;
  localparam int PHASE_LEN  = 160;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  cgl_pkg::in_t   in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  cgl_pkg::out_t  out_data;
  logic           cfg_we    = 1'b0;
  logic [15:0]    cfg_wdata = '0;

  // shadow stop table and register
  logic [15:0]      stop_pos_q [$];
  cgl_pkg::color_t  stop_col_q [$];
  int               stop_cnt   = 0;
  logic [15:0]      min_span_q = cgl_pkg::MIN_SPAN_RST;
  cgl_pkg::out_t    pending_colors [$];

  bit steady_flow = 1'b0;
  int err_count   = 0;
  int n_checked   = 0;
  int n_full      = 0;
  int n_empty     = 0;
  int n_blend     = 0;
  int n_settings  = 1;

  color_gradient_lookup #(.MAX_STOPS(STOP_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= steady_flow || ($urandom_range(99, 0) >= IDLE_PCT);
  end

  function automatic cgl_pkg::out_t color_result(cgl_pkg::color_t col);
    cgl_pkg::out_t res;
    res           = '0;
    res.out_red   = col[0];
    res.out_green = col[1];
    res.out_blue  = col[2];
    res.out_alpha = col[3];
    res.status    = cgl_pkg::STATUS_OK;
    return res;
  endfunction

  // one channel blended between two stops, truncated
  function automatic logic [15:0] blend_chan(logic [15:0] a, logic [15:0] b,
                                             logic [31:0] frac);
    logic [47:0] mix;
    mix = 48'(a) * 48'(32'd65536 - frac) + 48'(b) * 48'(frac);
    return mix[31:16];
  endfunction

  // expected result of one beat, updates the shadow table
  function automatic cgl_pkg::out_t predict_gradient(cgl_pkg::in_t beat);
    cgl_pkg::out_t   res;
    cgl_pkg::color_t col;
    cgl_pkg::color_t lo;
    cgl_pkg::color_t hi;
    int              slot;
    logic [31:0]     span;
    logic [31:0]     offs;
    logic [31:0]     frac;
    res = '0;
    res.status = cgl_pkg::STATUS_OK;
    if (beat.opcode == cgl_pkg::OP_INSERT) begin
      if (stop_cnt >= STOP_DEPTH) begin
        res.status = cgl_pkg::STATUS_FULL;
      end else begin
        // new stop lands after all stops at or below its position
        slot = 0;
        while (slot < stop_cnt && stop_pos_q[slot] <= beat.position) slot++;
        stop_pos_q.insert(slot, beat.position);
        stop_col_q.insert(slot, {beat.in_alpha, beat.in_blue, beat.in_green, beat.in_red});
        stop_cnt++;
      end
    end else if (stop_cnt == 0) begin
      res.status = cgl_pkg::STATUS_EMPTY;
    end else begin
      // first stop strictly above the query
      slot = 0;
      while (slot < stop_cnt && beat.position >= stop_pos_q[slot]) slot++;
      if (stop_cnt == 1 || slot == 0) begin
        res = color_result(stop_col_q[0]);
      end else if (slot == stop_cnt) begin
        res = color_result(stop_col_q[stop_cnt-1]);
      end else begin
        span = 32'(stop_pos_q[slot]) - 32'(stop_pos_q[slot-1]);
        offs = 32'(beat.position) - 32'(stop_pos_q[slot-1]);
        frac = (span > 32'(min_span_q)) ? (offs << 16) / span : 32'd0;
        lo = stop_col_q[slot-1];
        hi = stop_col_q[slot];
        col[0] = blend_chan(lo[0], hi[0], frac);
        col[1] = blend_chan(lo[1], hi[1], frac);
        col[2] = blend_chan(lo[2], hi[2], frac);
        col[3] = blend_chan(lo[3], hi[3], frac);
        res = color_result(col);
        n_blend++;
      end
    end
    return res;
  endfunction

  function automatic logic [15:0] rand_chan();
    logic [15:0] v;
    case ($urandom_range(5, 0))
      0:       v = 16'h0000;
      1:       v = 16'hFFFF;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic cgl_pkg::in_t make_beat(logic op, logic [15:0] pos);
    cgl_pkg::in_t b;
    b.opcode   = op;
    b.position = pos;
    b.in_red   = rand_chan();
    b.in_green = rand_chan();
    b.in_blue  = rand_chan();
    b.in_alpha = rand_chan();
    return b;
  endfunction

  function automatic cgl_pkg::in_t make_flat_stop(logic [15:0] pos, logic [15:0] chan);
    cgl_pkg::in_t b;
    b.opcode   = cgl_pkg::OP_INSERT;
    b.position = pos;
    b.in_red   = chan;
    b.in_green = chan;
    b.in_blue  = chan;
    b.in_alpha = chan;
    return b;
  endfunction

  // position on, just above or just below a stop, else anywhere
  function automatic logic [15:0] near_stop_pos();
    logic [15:0] base;
    logic [15:0] p;
    if (stop_cnt == 0) base = 16'($urandom);
    else base = stop_pos_q[$urandom_range(stop_cnt - 1, 0)];
    case ($urandom_range(3, 0))
      0:       p = base;
      1:       p = base + 16'($urandom_range(300, 1));
      2:       p = base - 16'($urandom_range(3, 1));
      default: p = 16'($urandom);
    endcase
    return p;
  endfunction

  function automatic cgl_pkg::in_t rand_lookup();
    logic [15:0] p;
    case ($urandom_range(7, 0))
      0:       p = 16'h0000;
      1:       p = 16'hFFFF;
      2, 3:    p = 16'($urandom);
      default: p = near_stop_pos();
    endcase
    return make_beat(cgl_pkg::OP_LOOKUP, p);
  endfunction

  // one input beat, with random idle cycles ahead of it
  task automatic send_beat(input cgl_pkg::in_t beat);
    while (!steady_flow && $urandom_range(99, 0) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= beat;
    in_valid <= 1'b1;
    pending_colors.push_back(predict_gradient(beat));
    do @(posedge clk); while (!in_ready);
  endtask

  // let every result come back and the block settle
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_min_span(input logic [15:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we     <= 1'b0;
    min_span_q  = v;
    n_settings++;
  endtask

  task automatic test_empty_table();
    send_beat(make_beat(cgl_pkg::OP_LOOKUP, 16'h0000));
    send_beat(make_beat(cgl_pkg::OP_LOOKUP, 16'hFFFF));
  endtask

  task automatic test_single_stop();
    send_beat(make_beat(cgl_pkg::OP_INSERT, 16'h4000));
    send_beat(make_beat(cgl_pkg::OP_LOOKUP, 16'h0000));
    send_beat(make_beat(cgl_pkg::OP_LOOKUP, 16'h4000));
    send_beat(make_beat(cgl_pkg::OP_LOOKUP, 16'hFFFF));
  endtask

  // black at zero, white at the top, blends across the whole range
  task automatic test_range_edges();
    send_beat(make_flat_stop(16'h0000, 16'h0000));
    send_beat(make_flat_stop(16'hFFFF, 16'hFFFF));
    send_beat(make_beat(cgl_pkg::OP_LOOKUP, 16'h0000));
    send_beat(make_beat(cgl_pkg::OP_LOOKUP, 16'h2000));
    send_beat(make_beat(cgl_pkg::OP_LOOKUP, 16'h3FFF));
    send_beat(make_beat(cgl_pkg::OP_LOOKUP, 16'h8000));
    send_beat(make_beat(cgl_pkg::OP_LOOKUP, 16'hFFFE));
    send_beat(make_beat(cgl_pkg::OP_LOOKUP, 16'hFFFF));
  endtask

  // duplicate positions and spans on both sides of the reset min_span
  task automatic test_equal_positions();
    send_beat(make_beat(cgl_pkg::OP_INSERT, 16'h4000));
    send_beat(make_beat(cgl_pkg::OP_LOOKUP, 16'h4000));
    send_beat(make_beat(cgl_pkg::OP_LOOKUP, 16'h3FFF));
    send_beat(make_beat(cgl_pkg::OP_INSERT, 16'h4028));
    send_beat(make_beat(cgl_pkg::OP_LOOKUP, 16'h4010));
    send_beat(make_beat(cgl_pkg::OP_INSERT, 16'h406B));
    send_beat(make_beat(cgl_pkg::OP_LOOKUP, 16'h4040));
  endtask

  // grow the table to full with lookups in between
  task automatic test_fill_table();
    while (stop_cnt < STOP_DEPTH) begin
      if ($urandom_range(9, 0) < 4) send_beat(make_beat(cgl_pkg::OP_INSERT, near_stop_pos()));
      else send_beat(rand_lookup());
    end
  endtask

  task automatic test_full_table();
    send_beat(make_flat_stop(16'h0000, 16'hFFFF));
    send_beat(make_flat_stop(16'hFFFF, 16'h0000));
    send_beat(make_beat(cgl_pkg::OP_INSERT, near_stop_pos()));
    send_beat(rand_lookup());
  endtask

  // one min_span setting, mostly lookups against the full table
  task automatic test_span_setting(input logic [15:0] span, input bit steady);
    wait_drain();
    write_min_span(span);
    steady_flow <= steady;
    repeat (PHASE_LEN) begin
      if ($urandom_range(9, 0) == 0) send_beat(make_beat(cgl_pkg::OP_INSERT, 16'($urandom)));
      else send_beat(rand_lookup());
    end
    steady_flow <= 1'b0;
  endtask

  // compare each result beat against the oldest expectation
  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : check_results
    cgl_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_colors.size() == 0) begin
        $display("%0t unexpected result beat: expected none actual %h", $time, out_data);
        err_count++;
      end else begin
        want = pending_colors.pop_front();
        check_field("out_red", want.out_red, out_data.out_red);
        check_field("out_green", want.out_green, out_data.out_green);
        check_field("out_blue", want.out_blue, out_data.out_blue);
        check_field("out_alpha", want.out_alpha, out_data.out_alpha);
        check_field("status", {14'd0, want.status}, {14'd0, out_data.status});
        n_checked++;
        if (want.status == cgl_pkg::STATUS_FULL) n_full++;
        if (want.status == cgl_pkg::STATUS_EMPTY) n_empty++;
      end
    end
  end

  // test sequence
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_single_stop();
    test_range_edges();
    test_equal_positions();
    test_fill_table();
    test_full_table();
    test_span_setting(16'd0, 1'b0);
    test_span_setting(16'hFFFF, 1'b0);
    test_span_setting(16'd1, 1'b0);
    test_span_setting(16'($urandom_range(1000, 2)), 1'b1);
    test_span_setting(16'($urandom_range(65535, 0)), 1'b0);
    test_span_setting(16'h0200, 1'b0);
    test_span_setting(cgl_pkg::MIN_SPAN_RST, 1'b0);
    wait_drain();
    repeat (60) @(posedge clk);
    $display("checked %0d result beats: %0d blended lookups, %0d dropped inserts, %0d empty lookups",
             n_checked, n_blend, n_full, n_empty);
    $display("table held %0d stops, %0d min_span settings visited", stop_cnt, n_settings);
    if (err_count == 0 && pending_colors.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
